FILE: hw/rtl/delayed_relay_switch_queue_assert.svh
// assertion macros for the delayed relay switch queue checker
`ifndef DELAYED_RELAY_SWITCH_QUEUE_ASSERT_SVH
`define DELAYED_RELAY_SWITCH_QUEUE_ASSERT_SVH

// property checked on every clock edge outside reset
`define DRSQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every clock edge, reset included
`define DRSQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/drsq_pkg.sv
// shared types and constants of the delayed relay switch queue
`timescale 1ns / 1ps

package drsq_pkg;

  // queue geometry
  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W    = 3;
  localparam int CNT_W     = SLOT_W + 1;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 64;

  // command byte encoding
  localparam logic [3:0] CMD_ON_NIB   = 4'h9;
  localparam logic [7:0] CMD_EMPTY    = 8'h00;
  localparam logic [7:0] CMD_OFF_BASE = 8'h80;

  // operation codes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // register indexes
  typedef enum logic [1:0] {
    REG_RELAY_MODE  = 2'd0,
    REG_OFF_DELAY   = 2'd1,
    REG_DELAY_BASE  = 2'd2,
    REG_DELAY_COUNT = 2'd3
  } reg_idx_t;

  // input word
  typedef struct packed {
    logic        operation;
    logic [2:0]  slot;
    logic [7:0]  command;
    logic [31:0] due_time;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [7:0] port_state;
    logic       port_changed;
    logic [7:0] fired_slots;
  } out_word_t;

  // one queue entry
  typedef struct packed {
    logic [7:0]  cmd;
    logic [31:0] due;
  } slot_entry_t;

  // configuration registers
  typedef struct packed {
    logic [7:0]  relay_mode;
    logic [7:0]  off_delay_enable;
    logic [31:0] delay_base_nibbles;
    logic [63:0] delay_count_bytes;
  } cfg_t;

  // slot memory access request
  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    slot_entry_t       wr_data;
  } mem_req_t;

endpackage

FILE: hw/rtl/drsq_regs.sv
// configuration register file with its bus port
`timescale 1ns / 1ps

module drsq_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [drsq_pkg::ADDR_W-1:0] paddr,
  input  logic [drsq_pkg::DATA_W-1:0] pwdata,
  output logic [drsq_pkg::DATA_W-1:0] prdata,
  output drsq_pkg::cfg_t              cfg
);

  drsq_pkg::cfg_t     cfg_r;
  drsq_pkg::cfg_t     cfg_nxt;
  drsq_pkg::reg_idx_t idx;
  logic               wr_hit;

  assign idx    = drsq_pkg::reg_idx_t'(paddr[4:3]);
  assign wr_hit = psel & penable & pwrite;

  // write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_hit) begin
      unique case (idx)
        drsq_pkg::REG_RELAY_MODE:  cfg_nxt.relay_mode         = pwdata[7:0];
        drsq_pkg::REG_OFF_DELAY:   cfg_nxt.off_delay_enable   = pwdata[7:0];
        drsq_pkg::REG_DELAY_BASE:  cfg_nxt.delay_base_nibbles = pwdata[31:0];
        drsq_pkg::REG_DELAY_COUNT: cfg_nxt.delay_count_bytes  = pwdata;
        default:                   cfg_nxt = cfg_r;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      drsq_pkg::REG_RELAY_MODE:  prdata = {56'd0, cfg_r.relay_mode};
      drsq_pkg::REG_OFF_DELAY:   prdata = {56'd0, cfg_r.off_delay_enable};
      drsq_pkg::REG_DELAY_BASE:  prdata = {32'd0, cfg_r.delay_base_nibbles};
      drsq_pkg::REG_DELAY_COUNT: prdata = cfg_r.delay_count_bytes;
      default:                   prdata = '0;
    endcase
  end

  // register storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hw/rtl/drsq_slot_mem.sv
// slot memory: one write and one registered read per cycle, entries read empty until written
`timescale 1ns / 1ps

module drsq_slot_mem (
  input  logic                  clk,
  input  logic                  rst_n,
  input  drsq_pkg::mem_req_t    req,
  output drsq_pkg::slot_entry_t rd_data
);

  drsq_pkg::slot_entry_t                 mem [drsq_pkg::NUM_SLOTS];
  logic [drsq_pkg::NUM_SLOTS-1:0]        vld_r;
  drsq_pkg::slot_entry_t                 rd_data_r;
  logic                                  rd_vld_r;

  // per-entry written flags, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= vld_r[req.rd_addr];
      end
    end
  end

  // storage array
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  // never-written entry reads as empty
  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

FILE: hw/rtl/delayed_relay_switch_queue.sv
// delayed relay switch queue top level: command sequencer and relay port
//
// Input words are taken on start while busy is low. A load word writes one
// queue slot (command byte and 32-bit due time); a tick word advances the
// elapsed counter and then walks the slots 0 to 7, firing each non-empty
// slot whose due time matches and switching the relay port bit.
// Each word gives one result word on out_word, shown for one cycle with
// out_strobe high; the receiver takes it then and cannot hold it off.
// A load's result is registered as its slot is written; a tick's as slot 7 is checked.
// A tick keeps busy high while it walks the slots: one slot memory read is issued per
// cycle and each entry is checked and written back the cycle after its read.
// A load keeps busy high only while it writes its slot. The next word may be accepted in the
// cycle its predecessor's result is shown.
// Configuration goes through the 64-bit register port (pready always high),
// registers at byte addresses 0, 8, 16, 24; write it only while idle.
// Reset clears the counter, the relay port, the registers and empties all
// slots at once through per-slot written flags; no clearing pass is needed.
`timescale 1ns / 1ps

module delayed_relay_switch_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  drsq_pkg::in_word_t          in_word,
  output logic                        out_strobe,
  output drsq_pkg::out_word_t         out_word,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [drsq_pkg::ADDR_W-1:0] paddr,
  input  logic [drsq_pkg::DATA_W-1:0] pwdata,
  output logic [drsq_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_TICK
  } state_t;

  state_t                       state_r, state_nxt;
  logic                         busy_r, busy_nxt;
  logic                         out_strobe_r, out_strobe_nxt;
  drsq_pkg::out_word_t          out_word_r, out_word_nxt;
  drsq_pkg::in_word_t           item_r, item_nxt;
  logic [31:0]                  elapsed_r, elapsed_nxt;
  logic [7:0]                   port_r, port_nxt;
  logic [7:0]                   fired_r, fired_nxt;
  logic [drsq_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;

  drsq_pkg::cfg_t               cfg;
  drsq_pkg::mem_req_t           mem_req;
  drsq_pkg::slot_entry_t        rd_data;

  logic                         accept;
  logic [drsq_pkg::CNT_W-1:0]   cnt_m1;
  logic [drsq_pkg::SLOT_W-1:0]  ev_idx;
  logic                         hit;
  logic                         is_on;
  logic [3:0]                   chan;
  logic [7:0]                   dly_count;
  logic [3:0]                   dly_base;
  logic [31:0]                  dly_ticks;
  logic                         rearm;

  // configuration registers
  drsq_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // slot queue storage
  drsq_slot_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  assign accept = start & ~busy_r;

  // decode of the entry read in the previous cycle
  assign cnt_m1    = cnt_r - drsq_pkg::CNT_W'(1);
  assign ev_idx    = cnt_m1[drsq_pkg::SLOT_W-1:0];
  assign hit       = (rd_data.cmd != drsq_pkg::CMD_EMPTY) && (rd_data.due == elapsed_r);
  assign is_on     = rd_data.cmd[7:4] == drsq_pkg::CMD_ON_NIB;
  assign chan      = rd_data.cmd[3:0];
  assign dly_count = cfg.delay_count_bytes[{ev_idx, 3'b000} +: 8];
  assign dly_base  = cfg.delay_base_nibbles[{ev_idx, 2'b00} +: 4];
  assign dly_ticks = {24'd0, dly_count} << dly_base;
  assign rearm     = is_on && cfg.off_delay_enable[ev_idx] && (dly_count != 8'd0);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    elapsed_nxt    = elapsed_r;
    port_nxt       = port_r;
    fired_nxt      = fired_r;
    cnt_nxt        = cnt_r;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = out_word_r;
    mem_req        = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          item_nxt = in_word;
          if (in_word.operation == drsq_pkg::OP_LOAD) begin
            state_nxt = ST_LOAD;
          end else begin
            state_nxt   = ST_TICK;
            elapsed_nxt = elapsed_r + 32'd1;
            cnt_nxt     = '0;
            fired_nxt   = '0;
          end
        end
      end

      ST_LOAD: begin
        // slots past the queue depth are ignored
        if ({1'b0, item_r.slot} < drsq_pkg::CNT_W'(drsq_pkg::NUM_SLOTS)) begin
          mem_req.wr_en       = 1'b1;
          mem_req.wr_addr     = item_r.slot;
          mem_req.wr_data.cmd = item_r.command;
          mem_req.wr_data.due = item_r.due_time;
        end
        out_strobe_nxt = 1'b1;
        out_word_nxt   = '{port_state: port_r, port_changed: 1'b0, fired_slots: 8'd0};
        state_nxt      = ST_IDLE;
      end

      ST_TICK: begin
        // issue the read of the next slot
        if (cnt_r < drsq_pkg::CNT_W'(drsq_pkg::NUM_SLOTS)) begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = cnt_r[drsq_pkg::SLOT_W-1:0];
        end
        // check and write back the slot read last cycle
        if (cnt_r != '0 && hit) begin
          fired_nxt[ev_idx] = 1'b1;
          if (!chan[3]) begin
            port_nxt[chan[2:0]] = is_on ^ cfg.relay_mode[chan[2:0]];
          end
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = ev_idx;
          if (rearm) begin
            mem_req.wr_data.cmd = drsq_pkg::CMD_OFF_BASE | {5'd0, ev_idx};
            mem_req.wr_data.due = elapsed_r + dly_ticks;
          end else begin
            mem_req.wr_data.cmd = drsq_pkg::CMD_EMPTY;
            mem_req.wr_data.due = rd_data.due;
          end
        end
        cnt_nxt = cnt_r + drsq_pkg::CNT_W'(1);
        // last slot checked: report
        if (cnt_r == drsq_pkg::CNT_W'(drsq_pkg::NUM_SLOTS)) begin
          out_strobe_nxt = 1'b1;
          out_word_nxt   = '{port_state: port_nxt, port_changed: (fired_nxt != 8'd0),
                             fired_slots: fired_nxt};
          state_nxt      = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    busy_nxt = state_nxt != ST_IDLE;
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      busy_r       <= 1'b0;
      out_strobe_r <= 1'b0;
      elapsed_r    <= '0;
      port_r       <= '0;
      cnt_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      busy_r       <= busy_nxt;
      out_strobe_r <= out_strobe_nxt;
      elapsed_r    <= elapsed_nxt;
      port_r       <= port_nxt;
      cnt_r        <= cnt_nxt;
    end
    item_r     <= item_nxt;
    fired_r    <= fired_nxt;
    out_word_r <= out_word_nxt;
  end

  assign busy       = busy_r;
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;
  assign pready     = 1'b1;

endmodule

FILE: hw/rtl/drsq_checker.sv
// port-level checker for the delayed relay switch queue and its bind
`timescale 1ns / 1ps
`include "delayed_relay_switch_queue_assert.svh"

module drsq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input drsq_pkg::in_word_t  in_word,
  input logic                out_strobe,
  input drsq_pkg::out_word_t out_word
);

  logic load_acc;
  logic load_clean;
  logic flag_ok;

  // accepted load word and what its result must show
  assign load_acc   = start && !busy && (in_word.operation == drsq_pkg::OP_LOAD);
  assign load_clean = !out_word.port_changed && (out_word.fired_slots == 8'd0);
  assign flag_ok    = out_word.port_changed == (out_word.fired_slots != 8'd0);

  // no result straight out of reset
  `DRSQ_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_strobe, "result word during reset")

  // an accepted word makes the block busy
  `DRSQ_ASSERT(a_busy_after_accept, (start && !busy) |=> busy, "busy low after accept")

  // an accepted load reports with nothing fired and the port unchanged
  `DRSQ_ASSERT(a_load_result, load_acc |-> ##2 (out_strobe && load_clean), "bad load result")

  // changed flag agrees with the fired mask
  `DRSQ_ASSERT(a_changed_flag, out_strobe |-> flag_ok, "port_changed disagrees with fired_slots")

endmodule

bind delayed_relay_switch_queue drsq_checker u_drsq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_word    (in_word),
  .out_strobe (out_strobe),
  .out_word   (out_word)
);

FILE: sim/delayed_relay_switch_queue_tb.sv
// testbench for the delayed relay switch queue: directed and random words against a predictor
`timescale 1ns / 1ps

module delayed_relay_switch_queue_tb;
  import drsq_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int SETTLE_CYCLES = 12;
  localparam int RAND_PHASES  = 7;
  localparam int PHASE_WORDS  = 200;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  in_word_t            in_word;
  logic                out_strobe;
  out_word_t           out_word;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // predictor state: shadow registers, counter, port and queue
  cfg_t        relay_cfg;
  logic [31:0] tick_count;
  logic [7:0]  relay_port;
  logic [7:0]  slot_cmd [NUM_SLOTS];
  logic [31:0] slot_due [NUM_SLOTS];

  out_word_t   expected_ports [$];
  int          error_count;
  int          words_sent;
  int          results_checked;
  int          firings_seen;
  int          cfg_settings;
  int          cycle_count;
  int          gap_pct;

  delayed_relay_switch_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // next port word for one accepted input word; updates the predictor state
  function automatic out_word_t predict_relay_word(input in_word_t w);
    out_word_t  r;
    logic [7:0] fired;
    logic [7:0] cmd;
    logic [3:0] ch;
    logic [7:0] cnt;
    logic [3:0] shamt;
    logic       on_evt;
    fired = '0;
    if (w.operation == OP_LOAD) begin
      slot_cmd[w.slot] = w.command;
      slot_due[w.slot] = w.due_time;
    end else begin
      tick_count = tick_count + 32'd1;
      for (int k = 0; k < NUM_SLOTS; k++) begin
        cmd = slot_cmd[k];
        if (cmd != CMD_EMPTY && slot_due[k] == tick_count) begin
          fired[k] = 1'b1;
          on_evt = (cmd[7:4] == CMD_ON_NIB);
          ch = cmd[3:0];
          // contact mode flips the sense of the switch; channels 8 and up do nothing
          if (ch < 4'd8)
            relay_port[ch[2:0]] = on_evt ^ relay_cfg.relay_mode[ch[2:0]];
          slot_cmd[k] = CMD_EMPTY;
          cnt = relay_cfg.delay_count_bytes[8*k +: 8];
          shamt = relay_cfg.delay_base_nibbles[4*k +: 4];
          // delayed off re-arm on the channel whose number is the slot index
          if (on_evt && relay_cfg.off_delay_enable[k] && cnt != 8'd0) begin
            slot_cmd[k] = CMD_OFF_BASE + 8'(k);
            slot_due[k] = tick_count + (32'(cnt) << shamt);
          end
        end
      end
    end
    r.port_state   = relay_port;
    r.port_changed = |fired;
    r.fired_slots  = fired;
    return r;
  endfunction

  // result checker: the receiver always takes the word
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_ports.size() == 0) begin
        $error("result word with nothing expected: %h", out_word);
        error_count++;
      end else begin
        out_word_t exp_w;
        exp_w = expected_ports.pop_front();
        results_checked++;
        firings_seen += $countones(out_word.fired_slots);
        if (out_word.port_state !== exp_w.port_state) begin
          $error("port_state expected %h got %h", exp_w.port_state, out_word.port_state);
          error_count++;
        end
        if (out_word.port_changed !== exp_w.port_changed) begin
          $error("port_changed expected %b got %b", exp_w.port_changed,
                 out_word.port_changed);
          error_count++;
        end
        if (out_word.fired_slots !== exp_w.fired_slots) begin
          $error("fired_slots expected %h got %h", exp_w.fired_slots, out_word.fired_slots);
          error_count++;
        end
      end
    end
  end

  // send one word and record its prediction at acceptance
  task automatic send_word(input in_word_t w);
    start <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_ports.push_back(predict_relay_word(w));
    words_sent++;
  endtask

  task automatic send_tick();
    in_word_t w;
    w.operation = OP_TICK;
    w.slot      = 3'($urandom);
    w.command   = 8'($urandom);
    w.due_time  = $urandom;
    send_word(w);
  endtask

  task automatic send_load(input logic [2:0] slot, input logic [7:0] cmd,
                           input logic [31:0] due);
    in_word_t w;
    w.operation = OP_LOAD;
    w.slot      = slot;
    w.command   = cmd;
    w.due_time  = due;
    send_word(w);
  endtask

  // random pause of the sender, taken with a chance of gap_pct percent
  task automatic maybe_gap();
    if ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // hold off until every expected word is back, optionally letting the block settle
  task automatic wait_results(input bit settle);
    start <= 1'b0;
    while (expected_ports.size() != 0) @(posedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write: setup cycle then access cycle
  task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_RELAY_MODE:  relay_cfg.relay_mode         = value[7:0];
      REG_OFF_DELAY:   relay_cfg.off_delay_enable   = value[7:0];
      REG_DELAY_BASE:  relay_cfg.delay_base_nibbles = value[31:0];
      REG_DELAY_COUNT: relay_cfg.delay_count_bytes  = value;
      default: ;
    endcase
  endtask

  task automatic write_all_regs(input logic [7:0] mode, input logic [7:0] off_en,
                                input logic [31:0] bases, input logic [63:0] counts);
    write_reg(REG_RELAY_MODE, 64'(mode));
    write_reg(REG_OFF_DELAY, 64'(off_en));
    write_reg(REG_DELAY_BASE, 64'(bases));
    write_reg(REG_DELAY_COUNT, counts);
    cfg_settings++;
  endtask

  // empty queue, empty load, far due times at the field extremes
  task automatic test_reset_state();
    send_tick();
    send_load(3'd7, 8'hFF, 32'hFFFF_FFFF);
    send_load(3'd0, CMD_EMPTY, tick_count + 32'd1);
    send_load(3'd1, 8'h91, 32'h0000_0000);
    send_tick();
  endtask

  // several slots in one tick, on then off on one channel, channels 8 and up
  task automatic test_port_switching();
    send_load(3'd0, 8'h93, tick_count + 32'd1);
    send_load(3'd1, 8'h83, tick_count + 32'd1);
    send_load(3'd2, 8'h9F, tick_count + 32'd1);
    send_load(3'd3, 8'h5A, tick_count + 32'd1);
    send_load(3'd4, 8'h90, tick_count + 32'd2);
    send_load(3'd5, 8'h97, tick_count + 32'd2);
    send_tick();
    send_tick();
  endtask

  // normally-closed contacts invert the switch
  task automatic test_closed_contacts();
    wait_results(1'b1);
    write_reg(REG_RELAY_MODE, 64'h0000_0000_0000_00E5);
    send_load(3'd6, 8'h95, tick_count + 32'd1);
    send_load(3'd7, 8'h06, tick_count + 32'd1);
    send_tick();
  endtask

  // on event re-armed as delayed off; zero count skips the re-arm
  task automatic test_delayed_off();
    wait_results(1'b1);
    write_reg(REG_OFF_DELAY, 64'h0000_0000_0000_00FF);
    write_reg(REG_DELAY_BASE, 64'h0000_0000_0001_0000);
    write_reg(REG_DELAY_COUNT, 64'h0000_0002_0000_0000);
    cfg_settings++;
    send_load(3'd4, 8'h91, tick_count + 32'd1);
    send_load(3'd5, 8'h92, tick_count + 32'd1);
    repeat (5) send_tick();
  endtask

  // random word, half loads, mostly due soon so slots really fire
  function automatic in_word_t random_word();
    in_word_t    w;
    int unsigned pick;
    logic [3:0]  ch;
    w.operation = ($urandom_range(0, 99) < 50) ? OP_TICK : OP_LOAD;
    w.slot = 3'($urandom_range(0, 7));
    ch = 4'($urandom_range(0, 9));
    pick = $urandom_range(0, 9);
    if (pick < 5)
      w.command = {CMD_ON_NIB, ch};
    else if (pick < 8)
      w.command = {4'($urandom_range(0, 15)), ch};
    else if (pick == 8)
      w.command = 8'($urandom);
    else
      w.command = CMD_EMPTY;
    if ($urandom_range(0, 99) < 80)
      w.due_time = tick_count + 32'($urandom_range(1, 12));
    else
      w.due_time = $urandom;
    return w;
  endfunction

  // phases of random traffic under different register settings
  task automatic test_random_traffic();
    in_word_t w;
    logic [31:0] bases;
    logic [63:0] counts;
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      wait_results(1'b1);
      if (phase == 0) begin
        write_all_regs(8'hFF, 8'hFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      end else if (phase == 1) begin
        write_all_regs(8'h00, 8'h00, 32'h0000_0000, 64'h0);
      end else begin
        bases = '0;
        counts = '0;
        // short delays so re-armed offs come due within the phase
        for (int k = 0; k < NUM_SLOTS; k++) begin
          bases[4*k +: 4]  = 4'($urandom_range(0, 2));
          counts[8*k +: 8] = 8'($urandom_range(0, 6));
        end
        write_all_regs(8'($urandom), 8'($urandom), bases, counts);
      end
      // last phase runs back to back, others with varied gap density
      case (phase % 3)
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 35;
      endcase
      if (phase == RAND_PHASES - 1) gap_pct = 0;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        w = random_word();
        send_word(w);
        if (phase != RAND_PHASES - 1 && $urandom_range(0, 99) == 0)
          wait_results(1'b0);
        else
          maybe_gap();
      end
    end
  endtask

  // main sequence
  initial begin
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_word <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    relay_cfg  = '0;
    tick_count = '0;
    relay_port = '0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      slot_cmd[k] = CMD_EMPTY;
      slot_due[k] = '0;
    end
    error_count     = 0;
    words_sent      = 0;
    results_checked = 0;
    firings_seen    = 0;
    cfg_settings    = 0;
    cycle_count     = 0;
    gap_pct         = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_port_switching();
    test_closed_contacts();
    test_delayed_off();
    test_random_traffic();

    wait_results(1'b0);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    $display("sent %0d words over %0d register settings, checked %0d results",
             words_sent, cfg_settings, results_checked);
    $display("saw %0d slot firings, elapsed counter reached %0d", firings_seen, tick_count);
    if (error_count == 0 && expected_ports.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
